[hw/rtl/vcsf_pkg.sv]
`default_nettype none
package vcsf_pkg;

  localparam int GridBits  = 5;
  localparam int CountBits = 8;
  localparam int IdxBits   = 3 * GridBits;
  localparam int Cells     = 1 << IdxBits;
  localparam int PtrBits   = IdxBits + 1;

  localparam logic [1:0] CmdClear    = 2'd0;
  localparam logic [1:0] CmdAdd      = 2'd1;
  localparam logic [1:0] CmdFinalize = 2'd2;
  localparam logic [1:0] CmdQuery    = 2'd3;

  localparam logic CfgMinPoints  = 1'b0;
  localparam logic CfgMinCluster = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] voxel_x;
    logic [4:0] voxel_y;
    logic [4:0] voxel_z;
  } in_item_t;

  typedef struct packed {
    logic        voxel_kept;
    logic [7:0]  voxel_points;
    logic [15:0] kept_total;
    logic        map_empty;
  } out_item_t;

endpackage
`default_nettype wire

[hw/rtl/vcsf_ram.sv]
`default_nettype none
// Simple dual-port RAM: one write and one registered read per cycle.
module vcsf_ram #(
  parameter int AddrBits = 15,
  parameter int DataBits = 8
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AddrBits-1:0] waddr,
  input  wire logic [DataBits-1:0] wdata,
  input  wire logic [AddrBits-1:0] raddr,
  output logic      [DataBits-1:0] rdata
);

  logic [DataBits-1:0] mem [1 << AddrBits];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/voxel_cluster_size_filter.sv]
`default_nettype none
// Voxel occupancy store with a 26-connected cluster size filter. Ready is
// low while a request is in progress. Add and query pass through idle, a RAM
// read, a write and the answer state. The clearing pass after reset sweeps
// all 32768 voxels one a cycle and then returns to idle. Clear does the same
// sweep and then answers as a query does. Finalize runs in four phases:
// - It clears the kept and visited flags of all 32768 voxels.
// - It scans every voxel, with a read state and a check state for each.
// - It walks each cluster. Every queued voxel is popped (pop, wait) and then
//   takes 27 probe steps (probe, wait, check), the voxel itself included.
// - It marks each kept cluster voxel by voxel, with a read and a write state.
// Finalize then answers as a query does. Each store has one write port and
// one registered read port. A result held back by the receiver stalls the
// answer state.
module voxel_cluster_size_filter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vcsf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vcsf_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);

  localparam int IB = vcsf_pkg::IdxBits;
  localparam int PB = vcsf_pkg::PtrBits;
  localparam int CB = vcsf_pkg::CountBits;
  localparam int GB = vcsf_pkg::GridBits;
  localparam logic [CB-1:0] CountMax = {CB{1'b1}};

  typedef enum logic [13:0] {
    StIdle    = 14'b00000000000001,
    StSweep   = 14'b00000000000010,
    StRead    = 14'b00000000000100,
    StWrite   = 14'b00000000001000,
    StRespond = 14'b00000000010000,
    StScan    = 14'b00000000100000,
    StScanChk = 14'b00000001000000,
    StPop     = 14'b00000010000000,
    StPopWait = 14'b00000100000000,
    StProbe   = 14'b00001000000000,
    StProbeW  = 14'b00010000000000,
    StProbeC  = 14'b00100000000000,
    StMark    = 14'b01000000000000,
    StMarkW   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [7:0]  min_points;
  logic [15:0] min_cluster;
  logic [15:0] kept_count;
  vcsf_pkg::in_item_t req;
  logic        sweep_all;
  logic [PB-1:0] sweep_ptr, seed, head, tail, mark_ptr;
  logic [IB-1:0] cur;
  logic [1:0]  ddx, ddy, ddz;
  logic [16:0] total;
  logic [CB-1:0] pts;
  logic        rst_done;

  // Memory ports.
  logic          cnt_we, kept_we, vis_we, q_we;
  logic [IB-1:0] cnt_wa, cnt_ra, kept_wa, kept_ra, vis_wa, vis_ra, q_wa, q_ra;
  logic [CB-1:0] cnt_wd, cnt_rd;
  logic          kept_wd, kept_rd, vis_wd, vis_rd;
  logic [IB-1:0] q_rd;
  logic [IB-1:0] q_wd_w;

  vcsf_ram #(.AddrBits(IB), .DataBits(CB)) u_cnt (.clk, .we(cnt_we), .waddr(cnt_wa),
    .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  vcsf_ram #(.AddrBits(IB), .DataBits(1)) u_kept (.clk, .we(kept_we), .waddr(kept_wa),
    .wdata(kept_wd), .raddr(kept_ra), .rdata(kept_rd));
  vcsf_ram #(.AddrBits(IB), .DataBits(1)) u_vis (.clk, .we(vis_we), .waddr(vis_wa),
    .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd));
  vcsf_ram #(.AddrBits(IB), .DataBits(IB)) u_q (.clk, .we(q_we), .waddr(q_wa),
    .wdata(q_wd_w), .raddr(q_ra), .rdata(q_rd));

  // Addressed voxel of the request.
  logic [IB-1:0] req_idx;
  assign req_idx = {req.voxel_z[GB-1:0], req.voxel_y[GB-1:0], req.voxel_x[GB-1:0]};

  // Neighbour of the current voxel for the probe offsets.
  logic [GB-1:0] cx, cy, cz, nx, ny, nz;
  logic nb_in, nb_self;
  logic [IB-1:0] nb_idx;
  always_comb begin
    cx = cur[GB-1:0];
    cy = cur[2*GB-1:GB];
    cz = cur[3*GB-1:2*GB];
    nx = cx + GB'(ddx) - GB'(1);
    ny = cy + GB'(ddy) - GB'(1);
    nz = cz + GB'(ddz) - GB'(1);
    nb_in = !((ddx == 2'd0 && cx == '0) || (ddx == 2'd2 && cx == '1) ||
              (ddy == 2'd0 && cy == '0) || (ddy == 2'd2 && cy == '1) ||
              (ddz == 2'd0 && cz == '0) || (ddz == 2'd2 && cz == '1));
    nb_self = (ddx == 2'd1) && (ddy == 2'd1) && (ddz == 2'd1);
    nb_idx = {nz, ny, nx};
  end

  logic [7:0]  need_pts;
  logic [16:0] need_cl;
  logic occ;
  assign need_pts = (min_points == 8'd0) ? 8'd1 : min_points;
  assign need_cl  = (min_cluster == 16'd0) ? 17'd1 : {1'b0, min_cluster};
  assign occ = ({{(16-CB){1'b0}}, cnt_rd} >= {8'd0, need_pts});

  // Memory port drive.
  always_comb begin
    cnt_we = 1'b0; kept_we = 1'b0; vis_we = 1'b0; q_we = 1'b0;
    cnt_wa = sweep_ptr[IB-1:0]; cnt_wd = '0; cnt_ra = req_idx;
    kept_wa = sweep_ptr[IB-1:0]; kept_wd = 1'b0; kept_ra = req_idx;
    vis_wa = sweep_ptr[IB-1:0]; vis_wd = 1'b0; vis_ra = seed[IB-1:0];
    q_wa = tail[IB-1:0]; q_wd_w = seed[IB-1:0]; q_ra = head[IB-1:0];
    unique case (state)
      StSweep: begin
        cnt_we = sweep_all; kept_we = 1'b1; vis_we = 1'b1;
      end
      StWrite: begin
        cnt_we = (req.command == vcsf_pkg::CmdAdd) && (cnt_rd != CountMax);
        cnt_wa = req_idx; cnt_wd = cnt_rd + CB'(1);
      end
      StScan: cnt_ra = seed[IB-1:0];
      StScanChk: begin
        if (!vis_rd && occ) begin
          vis_we = 1'b1; vis_wa = seed[IB-1:0]; vis_wd = 1'b1;
          q_we = 1'b1; q_wa = '0;
        end
      end
      StPop: q_ra = head[IB-1:0];
      StProbe, StProbeW: begin
        cnt_ra = nb_idx; vis_ra = nb_idx;
      end
      StProbeC: begin
        if (nb_in && !nb_self && !vis_rd && occ) begin
          vis_we = 1'b1; vis_wa = nb_idx; vis_wd = 1'b1;
          q_we = (tail < PB'(vcsf_pkg::Cells)); q_wa = tail[IB-1:0]; q_wd_w = nb_idx;
        end
      end
      StMark: q_ra = mark_ptr[IB-1:0];
      StMarkW: begin
        kept_we = 1'b1; kept_wa = q_rd; kept_wd = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StSweep; sweep_all <= 1'b1; sweep_ptr <= '0;
      min_points <= 8'd1; min_cluster <= 16'd1; kept_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vcsf_pkg::CfgMinPoints) min_points <= cfg_data[7:0];
        else min_cluster <= cfg_data;
      end
      if (state == StRespond && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (in_valid) begin
            req <= in_data; sweep_ptr <= '0; seed <= '0; total <= '0;
            unique case (in_data.command)
              vcsf_pkg::CmdClear: begin
                state <= StSweep; sweep_all <= 1'b1; kept_count <= '0;
              end
              vcsf_pkg::CmdFinalize: begin state <= StSweep; sweep_all <= 1'b0; end
              default: state <= StRead;
            endcase
          end
        end
        StSweep: begin
          sweep_ptr <= sweep_ptr + PB'(1);
          if (sweep_ptr == PB'(vcsf_pkg::Cells - 1)) begin
            if (!sweep_all) state <= StScan;
            else if (rst_done) state <= StRead;
            else state <= StIdle;
          end
        end
        StRead: state <= StWrite;
        StWrite: begin
          pts <= ((req.command == vcsf_pkg::CmdAdd) && (cnt_rd != CountMax)) ?
                 cnt_rd + CB'(1) : cnt_rd;
          state <= StRespond;
        end
        StRespond: begin
          if (!out_valid || out_ready) begin
            out_data.voxel_kept <= kept_rd;
            out_data.voxel_points <= pts;
            out_data.kept_total <= kept_count;
            out_data.map_empty <= (kept_count == 16'd0);
            state <= StIdle;
          end
        end
        StScan: state <= StScanChk;
        StScanChk: begin
          if (!vis_rd && occ) begin
            head <= '0; tail <= PB'(1); state <= StPop;
          end else if (seed == PB'(vcsf_pkg::Cells - 1)) begin
            kept_count <= total[16] ? 16'hFFFF : total[15:0];
            state <= StRead;
          end else begin
            seed <= seed + PB'(1); state <= StScan;
          end
        end
        StPop: begin
          if (head == tail) begin
            if ({1'b0, tail} >= need_cl) begin
              mark_ptr <= '0; state <= StMark;
              total <= total + {1'b0, tail};
            end else if (seed == PB'(vcsf_pkg::Cells - 1)) begin
              kept_count <= total[16] ? 16'hFFFF : total[15:0];
              state <= StRead;
            end else begin
              seed <= seed + PB'(1); state <= StScan;
            end
          end else begin
            head <= head + PB'(1); state <= StPopWait;
          end
        end
        StPopWait: begin
          cur <= q_rd; ddx <= '0; ddy <= '0; ddz <= '0; state <= StProbe;
        end
        StProbe: state <= StProbeW;
        StProbeW: state <= StProbeC;
        StProbeC: begin
          if (nb_in && !nb_self && !vis_rd && occ && tail < PB'(vcsf_pkg::Cells))
            tail <= tail + PB'(1);
          if (ddx == 2'd2 && ddy == 2'd2 && ddz == 2'd2) state <= StPop;
          else begin
            state <= StProbe;
            if (ddx != 2'd2) ddx <= ddx + 2'd1;
            else begin
              ddx <= '0;
              if (ddy != 2'd2) ddy <= ddy + 2'd1;
              else begin
                ddy <= '0; ddz <= ddz + 2'd1;
              end
            end
          end
        end
        StMark: state <= StMarkW;
        StMarkW: begin
          if (mark_ptr + PB'(1) == tail) begin
            if (seed == PB'(vcsf_pkg::Cells - 1)) begin
              kept_count <= total[16] ? 16'hFFFF : total[15:0];
              state <= StRead;
            end else begin
              seed <= seed + PB'(1); state <= StScan;
            end
          end else begin
            mark_ptr <= mark_ptr + PB'(1); state <= StMark;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // After the power-up pass there is no request to answer.
  always_ff @(posedge clk) begin
    if (rst) rst_done <= 1'b0;
    else if (state == StIdle && in_valid) rst_done <= 1'b1;
  end

  assign in_ready = (state == StIdle);

endmodule
`default_nettype wire

[hw/rtl/vcsf_checker.sv]
`default_nettype none
// Port-level checks on the filter.
module vcsf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire vcsf_pkg::out_item_t out_data
);

  // The empty flag always agrees with the total.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.map_empty == (out_data.kept_total == 16'd0)))
    else $error("map_empty disagrees with kept_total");

  // A request is not taken in the cycle after one was taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a request");

  // A waiting result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind voxel_cluster_size_filter vcsf_checker u_vcsf_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
